@@ rtl/asws_pkg.sv @@
`default_nettype none
package asws_pkg;

	localparam int unsigned WORD_W        = 32;
	localparam int unsigned MAX_ITEMS_DEF = 64;

	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} state_t;

	// link between neighboring cells
	typedef struct packed {
		logic              valid;
		logic              goes;   // incoming word belongs at or below this cell
		logic [WORD_W-1:0] value;
	} cell_link_t;

	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/asws_cell.sv @@
`default_nettype none
module asws_cell (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire asws_pkg::cell_ctrl_t    ctrl,
	input  wire [asws_pkg::WORD_W-1:0]   word,
	input  wire asws_pkg::cell_link_t    prev_lk,
	input  wire asws_pkg::cell_link_t    next_lk,
	output asws_pkg::cell_link_t         lk
);
	import asws_pkg::*;

	logic              valid_q;
	logic [WORD_W-1:0] value_q;
	logic              goes;

	assign goes = !valid_q || (word < value_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= next_lk.valid;
		end else if (ctrl.insert) begin
			valid_q <= valid_q | prev_lk.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q <= next_lk.value;
		end else if (ctrl.insert && goes) begin
			// larger neighbor below also moves up: take its word
			if (prev_lk.goes) begin
				value_q <= prev_lk.value;
			end else begin
				value_q <= word;
			end
		end
	end

	assign lk.valid = valid_q;
	assign lk.goes  = goes;
	assign lk.value = value_q;

endmodule
`default_nettype wire

@@ rtl/ascending_word_sorter.sv @@
`default_nettype none
// Ascending word sorter.
// Slave channel (s_*): one 32-bit word per transfer; s_tlast marks the
// last word of a set. Master channel (m_*): the set comes back in
// ascending order, one word per transfer, m_tlast on the largest word,
// m_tuser set on every word of a set that overflowed capacity.
// A row of MAX_ITEMS cells keeps the held words sorted: each accepted
// word is inserted as it is taken, every cell comparing against it in
// parallel and the larger words moving up one cell.
// Words beyond MAX_ITEMS are dropped and flag the whole set.
// After the tlast transfer the block stops taking input and drains the
// row from cell 0, one word per cycle while m_tready is high. The first
// result shows the cycle after the tlast transfer; input is taken again
// the cycle after the last result.
// A stalled receiver simply holds the row; cell 0 is the output register.
// Reset (arst_n low) empties the row, clears the count and the overflow
// flag and leaves the block ready for a new set.
module ascending_word_sorter #(
	parameter int unsigned MAX_ITEMS = asws_pkg::MAX_ITEMS_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        s_tvalid,
	output logic                       s_tready,
	input  wire [asws_pkg::WORD_W-1:0] s_tdata,   // [31:0] word_value
	input  wire                        s_tlast,   // set_end
	output logic                       m_tvalid,
	input  wire                        m_tready,
	output logic [asws_pkg::WORD_W-1:0] m_tdata,  // [31:0] sorted_value
	output logic                       m_tlast,   // run_end
	output logic                       m_tuser    // [0] overflow
);
	import asws_pkg::*;

	localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);

	state_t          state_q, state_nxt;
	logic [CntW-1:0] count_q;
	logic            dropped_q;
	logic            in_xfer, out_xfer, has_room, last_out;
	cell_ctrl_t      ctrl;
	cell_link_t      lk [MAX_ITEMS+1];
	cell_link_t      tail_lk;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;
	assign has_room = count_q < CntW'(MAX_ITEMS);
	assign last_out = count_q == CntW'(1);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_xfer && s_tlast) state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_xfer && last_out) state_nxt = ST_LOAD;
			end
			default: state_nxt = ST_LOAD;
		endcase
	end

	// outputs
	always_comb begin
		s_tready    = 1'b0;
		m_tvalid    = 1'b0;
		ctrl.insert = 1'b0;
		ctrl.shift  = 1'b0;
		case (state_q)
			ST_LOAD: begin
				s_tready    = 1'b1;
				ctrl.insert = s_tvalid && has_room;
			end
			ST_EMIT: begin
				m_tvalid   = 1'b1;
				ctrl.shift = m_tready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctrl.insert) begin
				count_q <= count_q + CntW'(1);
			end else if (ctrl.shift) begin
				count_q <= count_q - CntW'(1);
			end
			if (in_xfer && !has_room) begin
				dropped_q <= 1'b1;
			end else if (out_xfer && last_out) begin
				dropped_q <= 1'b0;
			end
		end
	end

	// head of the row: always valid, never takes the word
	assign lk[0].valid = 1'b1;
	assign lk[0].goes  = 1'b0;
	assign lk[0].value = '0;

	// past the top cell: empty
	assign tail_lk.valid = 1'b0;
	assign tail_lk.goes  = 1'b1;
	assign tail_lk.value = '0;

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		cell_link_t next_lk;
		if (i == MAX_ITEMS - 1) begin : g_top
			assign next_lk = tail_lk;
		end else begin : g_mid
			assign next_lk = lk[i+2];
		end
		asws_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.word    (s_tdata),
			.prev_lk (lk[i]),
			.next_lk (next_lk),
			.lk      (lk[i+1])
		);
	end

	assign m_tdata = lk[1].value;
	assign m_tlast = last_out;
	assign m_tuser = dropped_q;

endmodule
`default_nettype wire

@@ bench/ascending_word_sorter_test.sv @@
`timescale 1ns / 1ps

localparam int unsigned SORT_CAP = asws_pkg::MAX_ITEMS_DEF;

typedef struct packed {
	logic [asws_pkg::WORD_W-1:0] value;
	logic                        last;
	logic                        ovf;
} sorted_word_t;

// Keeps the current set in ascending order as words arrive and queues the
// sorted run once the set closes.
class sort_scoreboard;
	logic [asws_pkg::WORD_W-1:0] held [SORT_CAP];
	int                          fill;
	bit                          dropped;
	sorted_word_t                sorted_q [$];
	int                          errors;

	function new();
		fill    = 0;
		dropped = 1'b0;
		errors  = 0;
	endfunction

	function int pending();
		return sorted_q.size();
	endfunction

	task report(string msg);
		if (errors < 100)
			$display("%0t ns: %s", $time, msg);
		errors++;
	endtask

	// insertion keeps equal words in arrival order
	function void note_word(logic [asws_pkg::WORD_W-1:0] w, logic closing);
		int           j;
		sorted_word_t r;
		if (fill < SORT_CAP) begin
			j = fill;
			while (j > 0 && held[j-1] > w) begin
				held[j] = held[j-1];
				j--;
			end
			held[j] = w;
			fill++;
		end else begin
			dropped = 1'b1;
		end
		if (!closing)
			return;
		for (j = 0; j < fill; j++) begin
			r.value = held[j];
			r.last  = (j == fill - 1);
			r.ovf   = dropped;
			sorted_q.push_back(r);
		end
		fill    = 0;
		dropped = 1'b0;
	endfunction

	task check_result(logic [asws_pkg::WORD_W-1:0] v, logic l, logic o);
		sorted_word_t e;
		if (sorted_q.size() == 0) begin
			report($sformatf("result %h with nothing outstanding", v));
			return;
		end
		e = sorted_q.pop_front();
		if (v !== e.value)
			report($sformatf("sorted_value %h, want %h", v, e.value));
		if (l !== e.last)
			report($sformatf("run_end %b, want %b (value %h)", l, e.last, e.value));
		if (o !== e.ovf)
			report($sformatf("overflow %b, want %b (value %h)", o, e.ovf, e.value));
	endtask
endclass

module ascending_word_sorter_test;

	logic                        clk;
	logic                        arst_n;
	logic                        s_tvalid;
	logic                        s_tready;
	logic [asws_pkg::WORD_W-1:0] s_tdata;   // [31:0] word_value
	logic                        s_tlast;   // set_end
	logic                        m_tvalid;
	logic                        m_tready;
	logic [asws_pkg::WORD_W-1:0] m_tdata;   // [31:0] sorted_value
	logic                        m_tlast;   // run_end
	logic                        m_tuser;   // [0] overflow

	sort_scoreboard sb = new();
	bit             tx_quiet;               // sender skips its gaps for this set

	ascending_word_sorter #(
		.MAX_ITEMS(SORT_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Offer one word, hold it until the transfer, then log it for prediction.
	// s_tvalid is only dropped when a gap follows, so back-to-back words keep
	// it high without a second assignment in the same step.
	task automatic send_word(input logic [asws_pkg::WORD_W-1:0] w, input logic closing);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		s_tlast  <= closing;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_word(w, closing);
	endtask

	// Mix of full-range words, tiny values (many duplicates) and words near
	// the top of the range.
	function automatic logic [asws_pkg::WORD_W-1:0] draw_word();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 7);
			1: return 32'hFFFF_FFF8 | $urandom_range(0, 7);
			default: return $urandom;
		endcase
	endfunction

	// Sender: directed sets, then random sets, then drain and verdict.
	initial begin
		int n;
		int k;
		int set_no;
		int random_words;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		tx_quiet = 1'b0;
		arst_n   = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-word sets at both extremes
		send_word(32'h0000_0000, 1'b1);
		send_word(32'hFFFF_FFFF, 1'b1);
		// extremes and sign-bit neighbors, unsorted
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'h0000_0000, 1'b0);
		send_word(32'h8000_0000, 1'b0);
		send_word(32'h7FFF_FFFF, 1'b0);
		send_word(32'h0000_0001, 1'b1);
		// all equal
		tx_quiet = 1'b1;
		for (k = 0; k < 4; k++)
			send_word(32'd5, k == 3);
		// strictly descending, then already ascending
		tx_quiet = 1'b0;
		for (k = 0; k < 8; k++)
			send_word(32'd9 - k, k == 7);
		for (k = 0; k < 4; k++)
			send_word(k, k == 3);

		// Random sets: mostly short, one exactly at capacity and one past it
		// (the closing word and up to two before it get dropped).
		set_no       = 0;
		random_words = 0;
		while (random_words < 200) begin
			if (set_no == 3)
				n = SORT_CAP;
			else if (set_no == 6)
				n = SORT_CAP + 1 + $urandom_range(0, 2);
			else
				n = $urandom_range(1, 10);
			tx_quiet = ($urandom_range(0, 3) == 0);
			for (k = 0; k < n; k++)
				send_word(draw_word(), k == n - 1);
			random_words += n;
			set_no++;
		end
		s_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		// catch any stray results past the last expected one
		repeat (2 * SORT_CAP + 20) @(posedge clk);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Receiver: random stalls, calm stretches, and one long hold-off that
	// backs the block up into its input while the sender keeps offering.
	initial begin
		int stall;
		int taken;
		bit held_off;
		m_tready = 1'b0;
		taken    = 0;
		held_off = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held_off && taken == 40) begin
				stall    = 300;
				held_off = 1'b1;
			end else if ((taken / 16) % 4 == 1) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, 14);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			sb.check_result(m_tdata, m_tlast, m_tuser);
			taken++;
		end
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
